// File: hdl/ffpt_pkg.sv
// Shared types, codes and helpers of the force-field PI torque controller.
// No dependencies; used by every module, and its types fill the channel interface.
package ffpt_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_START_POSE  = 2'd0,
    KIND_START_JOINT = 2'd1,
    KIND_CYCLE_POSE  = 2'd2,
    KIND_CYCLE_JOINT = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FIELD_GAIN        = 3'd0,
    REG_TORQUE_STEP_LIMIT = 3'd1,
    REG_SMOOTHING_GAIN    = 3'd2,
    REG_TARGET_MASS       = 3'd3,
    REG_TARGET_PROP_GAIN  = 3'd4,
    REG_TARGET_INTEG_GAIN = 3'd5,
    REG_ASSIST_WEIGHT     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         joint;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
    logic signed [31:0] value_f;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_joint;
    logic signed [31:0] torque_command;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [31:0] wdata;
  } cfg_word_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_JOINT_PRE,
    ST_MUL,
    ST_ACC,
    ST_WB,
    ST_RESULT,
    ST_POSE_END
  } state_t;

  // multiplier operand selects
  typedef enum logic [3:0] {
    X_K, X_T, X_MASS, X_AW, X_A, X_B, X_C, X_PER, X_KP, X_KI, X_TMASS, X_TKP, X_TKI
  } xsel_t;

  typedef enum logic [3:0] {
    Y_V0, Y_V1, Y_V2, Y_C30, Y_C40, Y_NQG, Y_QG, Y_F0, Y_F1, Y_F2, Y_ERR, Y_INT, Y_G, Y_OMG
  } ysel_t;

  // accumulator start value
  typedef enum logic [1:0] {
    INIT_KEEP, INIT_ZERO, INIT_INT, INIT_TAUD
  } init_t;

  // write-back destinations
  typedef enum logic [3:0] {
    DST_NONE, DST_T, DST_F0, DST_F1, DST_F2, DST_TAUD, DST_INT, DST_CMD,
    DST_SMASS, DST_SKP, DST_SKI
  } dest_t;

  // what follows a write-back
  typedef enum logic [1:0] {
    FIN_NO, FIN_POSE, FIN_RESULT, FIN_DONE
  } fin_t;

  typedef struct packed {
    xsel_t      x_sel;
    ysel_t      y_sel;
    init_t      init;
    logic       neg;
    dest_t      dest;
    fin_t       fin;
  } uop_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  // microprogram of the multiply-accumulate sequencer
  function automatic uop_t ffpt_uop(input logic is_joint, input logic [3:0] step);
    uop_t u;
    u = '{X_K, Y_V0, INIT_ZERO, 1'b0, DST_NONE, FIN_DONE};
    if (!is_joint) begin
      case (step)
        4'd0:    u = '{X_K,    Y_V2,  INIT_ZERO, 1'b0, DST_NONE, FIN_NO};
        4'd1:    u = '{X_K,    Y_V1,  INIT_KEEP, 1'b1, DST_T,    FIN_NO};
        4'd2:    u = '{X_T,    Y_C30, INIT_ZERO, 1'b0, DST_F0,   FIN_NO};
        4'd3:    u = '{X_K,    Y_V0,  INIT_ZERO, 1'b0, DST_NONE, FIN_NO};
        4'd4:    u = '{X_K,    Y_V2,  INIT_KEEP, 1'b1, DST_T,    FIN_NO};
        4'd5:    u = '{X_T,    Y_C40, INIT_ZERO, 1'b0, DST_F1,   FIN_NO};
        4'd6:    u = '{X_K,    Y_V1,  INIT_ZERO, 1'b0, DST_NONE, FIN_NO};
        4'd7:    u = '{X_K,    Y_V0,  INIT_KEEP, 1'b1, DST_T,    FIN_NO};
        4'd8:    u = '{X_T,    Y_C40, INIT_ZERO, 1'b0, DST_NONE, FIN_NO};
        4'd9:    u = '{X_MASS, Y_NQG, INIT_KEEP, 1'b0, DST_NONE, FIN_NO};
        4'd10:   u = '{X_AW,   Y_QG,  INIT_KEEP, 1'b0, DST_F2,   FIN_POSE};
        default: u = '{X_K,    Y_V0,  INIT_ZERO, 1'b0, DST_NONE, FIN_DONE};
      endcase
    end else begin
      case (step)
        4'd0:    u = '{X_A,     Y_F0,  INIT_ZERO, 1'b0, DST_NONE,  FIN_NO};
        4'd1:    u = '{X_B,     Y_F1,  INIT_KEEP, 1'b0, DST_NONE,  FIN_NO};
        4'd2:    u = '{X_C,     Y_F2,  INIT_KEEP, 1'b0, DST_TAUD,  FIN_NO};
        4'd3:    u = '{X_PER,   Y_ERR, INIT_INT,  1'b0, DST_INT,   FIN_NO};
        4'd4:    u = '{X_KP,    Y_ERR, INIT_TAUD, 1'b0, DST_NONE,  FIN_NO};
        4'd5:    u = '{X_KI,    Y_INT, INIT_KEEP, 1'b0, DST_CMD,   FIN_RESULT};
        4'd6:    u = '{X_TMASS, Y_G,   INIT_ZERO, 1'b0, DST_NONE,  FIN_NO};
        4'd7:    u = '{X_MASS,  Y_OMG, INIT_KEEP, 1'b0, DST_SMASS, FIN_NO};
        4'd8:    u = '{X_TKP,   Y_G,   INIT_ZERO, 1'b0, DST_NONE,  FIN_NO};
        4'd9:    u = '{X_KP,    Y_OMG, INIT_KEEP, 1'b0, DST_SKP,   FIN_NO};
        4'd10:   u = '{X_TKI,   Y_G,   INIT_ZERO, 1'b0, DST_NONE,  FIN_NO};
        4'd11:   u = '{X_KI,    Y_OMG, INIT_KEEP, 1'b0, DST_SKI,   FIN_DONE};
        default: u = '{X_K,     Y_V0,  INIT_ZERO, 1'b0, DST_NONE,  FIN_DONE};
      endcase
    end
    return u;
  endfunction

endpackage

// File: hdl/ffpt_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from ffpt_pkg at instantiation.
interface ffpt_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/ffpt_div.sv
// Restoring signed divider, one quotient bit per cycle, saturated to 32 bits.
// Depends on ffpt_pkg for sat32.
module ffpt_div import ffpt_pkg::*; #(
  parameter int NW = 49
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [31:0]   den,
  output logic                 busy,
  output logic                 done,
  output logic signed [31:0]   quot
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0]      cnt;
  logic [31:0]        rem;
  logic [NW-1:0]      dvd;
  logic [31:0]        dmag;
  logic               neg;
  logic [32:0]        rsh;
  logic               qbit;
  logic signed [NW:0] qs;

  // trial subtract of the shifted remainder
  always_comb begin
    rsh  = {rem, dvd[NW-1]};
    qbit = (rsh >= {1'b0, dmag});
    qs   = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        dvd  <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag <= den[31] ? 32'(-den) : 32'(den);
        neg  <= num[NW-1] ^ den[31];
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= qbit ? 32'(rsh - {1'b0, dmag}) : rsh[31:0];
          dvd <= {dvd[NW-2:0], qbit};
          cnt <= cnt - 1'b1;
        end else begin
          quot <= sat32(66'(qs));
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/force_field_pi_torque_controller_top.sv
// Force-field PI torque controller with torque rate limit, top level.
// Depends on ffpt_pkg, ffpt_chan_if and ffpt_div.
//
// Channels: item (sink) takes input words of kind start pose, start joint,
// cycle pose or cycle joint; result (source) gives one word per cycle-joint
// item with a joint in range; cfg (sink) writes the seven registers and is
// always ready.
// Sequencing: start items finish in the accept cycle. A cycle pose runs three
// divisions, one bit a cycle in the shared divider (a zero period skips the
// divider and gives zero velocity), and then eleven multiply-accumulate steps.
// A cycle joint runs its multiply-accumulate steps to its result; the last
// joint then goes on to smooth the gains. The single shared 32x32 multiplier
// and the bit-serial divider carry all of this work.
// item.ready is high only while the sequencer is idle. A result waits in the
// output register; a stalled receiver holds the sequencer in the result step.
// Reset (synchronous) clears the configuration, positions, biases, integrators,
// period and smoothed gains, and sets the step limit and smoothing gain to 1.0.
module force_field_pi_torque_controller_top import ffpt_pkg::*; #(
  parameter int NUM_JOINTS = 7,
  parameter int FRAC_BITS  = 16
) (
  input logic         clk,
  input logic         rst,
  ffpt_chan_if.sink   item,
  ffpt_chan_if.source result,
  ffpt_chan_if.sink   cfg
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int NW = 33 + FRAC_BITS;
  localparam logic [63:0] QONE64 = 64'd1 << FRAC_BITS;
  localparam logic [63:0] QG64 = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic signed [31:0] Q_ONE = QONE64[31:0];
  localparam logic signed [31:0] Q_G = QG64[31:0];
  localparam logic signed [31:0] Q_NG = -Q_G;
  localparam logic signed [31:0] Q_30 = 32'(64'd30 << FRAC_BITS);
  localparam logic signed [31:0] Q_40 = 32'(64'd40 << FRAC_BITS);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // configuration registers
  logic signed [31:0] field_gain, smooth_g, target_mass, target_kp, target_ki;
  logic signed [31:0] assist_weight;
  logic [30:0]        step_limit;

  // controller state
  logic signed [31:0] last_pos [3];
  logic signed [31:0] wanted [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] bias [NUM_JOINTS];
  logic signed [31:0] integ [NUM_JOINTS];
  logic signed [31:0] step_period, smoothed_mass, smoothed_kp, smoothed_ki;

  // sequencer and datapath
  state_t             state, state_next;
  logic [3:0]         step;
  logic [1:0]         axis;
  in_item_t           item_r;
  uop_t               uop;
  logic signed [31:0] xop, yop, tmp, tau_ext_r, tau_d_r, err_r, cmd_r;
  logic signed [63:0] prod, rprod;
  logic signed [65:0] acc;
  logic signed [31:0] tau_d_new;
  logic               item_fire, joint_ok, joint_r_ok, last_joint, out_free;
  logic [4:0]         jz_in, jz;
  logic [JW-1:0]      jidx_in, jidx;
  logic signed [31:0] omg;

  // divider hookup
  logic               div_start, div_busy, div_done;
  logic signed [31:0] div_quot, pos_sel;
  logic signed [32:0] delta;
  logic signed [NW-1:0] div_num;

  // result path
  logic               out_valid;
  out_item_t          out_r;
  logic signed [32:0] diff, lim, diff_c;
  logic signed [31:0] res_val;

  assign item_fire = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.data = out_r;
  assign out_free = !out_valid || result.ready;

  assign jz_in = {2'b00, item.data.joint};
  assign jz = {2'b00, item_r.joint};
  assign jidx_in = jz_in[JW-1:0];
  assign jidx = jz[JW-1:0];
  assign joint_ok = (jz_in < 5'(NUM_JOINTS));
  assign joint_r_ok = (jz < 5'(NUM_JOINTS));
  assign last_joint = (jz == 5'(NUM_JOINTS - 1));
  assign omg = Q_ONE - smooth_g;

  assign uop = ffpt_uop(item_r.kind == KIND_CYCLE_JOINT, step);

  // operand selection
  always_comb begin
    case (uop.x_sel)
      X_K:     xop = field_gain;
      X_T:     xop = tmp;
      X_MASS:  xop = smoothed_mass;
      X_AW:    xop = assist_weight;
      X_A:     xop = item_r.value_a;
      X_B:     xop = item_r.value_b;
      X_C:     xop = item_r.value_c;
      X_PER:   xop = step_period;
      X_KP:    xop = smoothed_kp;
      X_KI:    xop = smoothed_ki;
      X_TMASS: xop = target_mass;
      X_TKP:   xop = target_kp;
      X_TKI:   xop = target_ki;
      default: xop = '0;
    endcase
    case (uop.y_sel)
      Y_V0:    yop = vel[0];
      Y_V1:    yop = vel[1];
      Y_V2:    yop = vel[2];
      Y_C30:   yop = Q_30;
      Y_C40:   yop = Q_40;
      Y_NQG:   yop = Q_NG;
      Y_QG:    yop = Q_G;
      Y_F0:    yop = wanted[0];
      Y_F1:    yop = wanted[1];
      Y_F2:    yop = wanted[2];
      Y_ERR:   yop = err_r;
      Y_INT:   yop = integ[jidx];
      Y_G:     yop = smooth_g;
      Y_OMG:   yop = omg;
      default: yop = '0;
    endcase
  end

  // rounded product and pending torque sum
  assign rprod = (prod + HALF) >>> FRAC_BITS;
  assign tau_d_new = sat32(acc);

  // divider numerator: position delta scaled to Q
  always_comb begin
    case (axis)
      2'd0:    pos_sel = item_r.value_a;
      2'd1:    pos_sel = item_r.value_b;
      default: pos_sel = item_r.value_c;
    endcase
    delta = 33'(pos_sel) - 33'(last_pos[axis]);
    div_num = {delta, FRAC_BITS'(0)};
  end

  // rate limit against the last command
  always_comb begin
    diff = 33'(cmd_r) - 33'(item_r.value_f);
    lim = $signed({2'b00, step_limit});
    if (diff > lim) diff_c = lim;
    else if (diff < -lim) diff_c = -lim;
    else diff_c = diff;
    res_val = sat32(66'(item_r.value_f) + 66'(diff_c));
  end

  ffpt_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (item_r.value_d),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_fire) begin
          if (item.data.kind == KIND_CYCLE_POSE) state_next = ST_DIV_START;
          else if (item.data.kind == KIND_CYCLE_JOINT && joint_ok) state_next = ST_JOINT_PRE;
        end
      end
      ST_DIV_START: begin
        if (item_r.value_d == '0) begin
          if (axis == 2'd2) state_next = ST_MUL;
        end else begin
          div_start = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = (axis == 2'd2) ? ST_MUL : ST_DIV_START;
      end
      ST_JOINT_PRE: state_next = ST_MUL;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = (uop.dest != DST_NONE) ? ST_WB : ST_MUL;
      ST_WB: begin
        case (uop.fin)
          FIN_POSE:   state_next = ST_POSE_END;
          FIN_RESULT: state_next = ST_RESULT;
          FIN_DONE:   state_next = ST_IDLE;
          default:    state_next = ST_MUL;
        endcase
      end
      ST_RESULT: begin
        if (out_free) state_next = last_joint ? ST_MUL : ST_IDLE;
      end
      ST_POSE_END: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      field_gain <= '0;
      step_limit <= 31'(QONE64);
      smooth_g <= Q_ONE;
      target_mass <= '0;
      target_kp <= '0;
      target_ki <= '0;
      assist_weight <= '0;
      for (int i = 0; i < 3; i++) begin
        last_pos[i] <= '0;
        wanted[i] <= '0;
      end
      for (int i = 0; i < NUM_JOINTS; i++) begin
        bias[i] <= '0;
        integ[i] <= '0;
      end
      step_period <= '0;
      smoothed_mass <= '0;
      smoothed_kp <= '0;
      smoothed_ki <= '0;
      step <= '0;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      // register writes
      if (cfg.valid) begin
        case (cfg.data.reg_index)
          REG_FIELD_GAIN:        field_gain <= cfg.data.wdata;
          REG_TORQUE_STEP_LIMIT: step_limit <= cfg.data.wdata[30:0];
          REG_SMOOTHING_GAIN:
            smooth_g <= (32'(cfg.data.wdata[16:0]) > 32'(Q_ONE)) ?
                        Q_ONE : 32'(cfg.data.wdata[16:0]);
          REG_TARGET_MASS:       target_mass <= cfg.data.wdata;
          REG_TARGET_PROP_GAIN:  target_kp <= cfg.data.wdata;
          REG_TARGET_INTEG_GAIN: target_ki <= cfg.data.wdata;
          REG_ASSIST_WEIGHT:     assist_weight <= cfg.data.wdata;
          default: ;
        endcase
      end

      // accepted word: start items finish here
      if (item_fire) begin
        item_r <= item.data;
        step <= '0;
        axis <= '0;
        if (item.data.kind == KIND_START_POSE) begin
          last_pos[0] <= item.data.value_a;
          last_pos[1] <= item.data.value_b;
          last_pos[2] <= item.data.value_c;
          for (int i = 0; i < NUM_JOINTS; i++) integ[i] <= '0;
        end else if (item.data.kind == KIND_START_JOINT && joint_ok) begin
          bias[jidx_in] <= sat32(66'(item.data.value_a) - 66'(item.data.value_b));
        end
      end

      // output register
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
        out_r.out_joint <= item_r.joint;
        out_r.torque_command <= res_val;
        step <= step + 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_DIV_START: begin
          if (item_r.value_d == '0) begin
            vel[axis] <= '0;
            axis <= axis + 1'b1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            vel[axis] <= div_quot;
            axis <= axis + 1'b1;
          end
        end
        ST_JOINT_PRE: begin
          tau_ext_r <= sat32(66'(item_r.value_d) - 66'(item_r.value_e) - 66'(bias[jidx]));
        end
        ST_MUL: begin
          prod <= xop * yop;
          case (uop.init)
            INIT_ZERO: acc <= '0;
            INIT_INT:  acc <= 66'(integ[jidx]);
            INIT_TAUD: acc <= 66'(tau_d_r);
            default: ;
          endcase
        end
        ST_ACC: begin
          acc <= uop.neg ? acc - 66'(rprod) : acc + 66'(rprod);
          if (uop.dest == DST_NONE) step <= step + 1'b1;
        end
        ST_WB: begin
          case (uop.dest)
            DST_T:  tmp <= tau_d_new;
            DST_F0: wanted[0] <= tau_d_new;
            DST_F1: wanted[1] <= tau_d_new;
            DST_F2: wanted[2] <= tau_d_new;
            DST_TAUD: begin
              tau_d_r <= tau_d_new;
              err_r <= sat32(66'(tau_d_new) - 66'(tau_ext_r));
            end
            DST_INT:   integ[jidx] <= tau_d_new;
            DST_CMD:   cmd_r <= tau_d_new;
            DST_SMASS: smoothed_mass <= tau_d_new;
            DST_SKP:   smoothed_kp <= tau_d_new;
            DST_SKI:   smoothed_ki <= tau_d_new;
            default: ;
          endcase
          if (uop.fin == FIN_NO) step <= step + 1'b1;
        end
        ST_POSE_END: begin
          step_period <= item_r.value_d;
          last_pos[0] <= item_r.value_a;
          last_pos[1] <= item_r.value_b;
          last_pos[2] <= item_r.value_c;
        end
        default: ;
      endcase
    end
  end

  // a pending result is never overwritten while the receiver stalls
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_valid && !result.ready) |=> (state == ST_RESULT))
    else $error("result step left while output register was full");

  // the divider only runs while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV_WAIT))
    else $error("divider busy outside the divide wait step");

  // joint work only runs for a joint in range
  a_joint_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_JOINT_PRE || state == ST_RESULT) |-> joint_r_ok)
    else $error("joint sequence started for an out-of-range joint");

endmodule
